@@ hw/rtl/packet_slot_buffer_macros.svh @@
// Assertion macros shared by the packet slot buffer RTL.
`ifndef PACKET_SLOT_BUFFER_MACROS_SVH
`define PACKET_SLOT_BUFFER_MACROS_SVH

// Same-cycle implication, checked outside of reset.
`define PSB_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("packet_slot_buffer: same-cycle check failed");

// Next-cycle implication, checked outside of reset.
`define PSB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("packet_slot_buffer: next-cycle check failed");

`endif

@@ hw/rtl/psb_pkg.sv @@
// Types, codes and the header rewrite function of the packet slot buffer.
`default_nettype none

package psb_pkg;

   localparam int DATA_W = 64;
   localparam int CTRL_W = 8;

   localparam logic ACTION_INGRESS = 1'b0;
   localparam logic ACTION_PULL    = 1'b1;

   localparam logic [CTRL_W-1:0] CTRL_DATA   = 8'h00;
   localparam logic [CTRL_W-1:0] CTRL_HEADER = 8'hff;

   localparam logic [1:0] STATUS_WORD     = 2'd0;
   localparam logic [1:0] STATUS_NO_SLOT  = 2'd1;
   localparam logic [1:0] STATUS_NO_READY = 2'd2;
   localparam logic [1:0] STATUS_TOO_LONG = 2'd3;

   typedef struct packed {
      logic              action;
      logic [CTRL_W-1:0] in_ctrl;
      logic [DATA_W-1:0] in_data;
   } psb_req_type;

   typedef struct packed {
      logic [CTRL_W-1:0] emit_ctrl;
      logic [DATA_W-1:0] emit_data;
      logic              last_word;
      logic [1:0]        status;
   } psb_rsp_type;

   typedef enum logic {
      PSB_IDLE,
      PSB_STREAM
   } psb_state_type;

   // What the read stage holds: a status result with zero data, a stored word
   // passed as is, or a stored first word that gets the header treatment.
   typedef enum logic [1:0] {
      KIND_RESULT,
      KIND_RAW,
      KIND_HEADER
   } psb_kind_type;

   // Swaps the two top bytes, then optionally replaces bits 63:48 with the
   // neighbor of the one-hot decode of the source port in bits 31:16.
   function automatic logic [DATA_W-1:0] header_word(input logic [DATA_W-1:0] w,
                                                     input logic rewrite);
      logic [DATA_W-1:0] r;
      logic [15:0]       src;
      logic [15:0]       dec;
      logic [15:0]       dest;
      r    = {w[55:48], w[63:56], w[47:0]};
      src  = r[31:16];
      dec  = (src[15:4] == 12'd0) ? (16'h0001 << src[3:0]) : 16'h0000;
      dest = src[0] ? (dec >> 1) : (dec << 1);
      if (rewrite) begin
         r[63:48] = dest;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/psb_store.sv @@
// Packet word store: one write port and one read port with registered read data.
`default_nettype none

module psb_store import psb_pkg::*; #(
   parameter int WORDS = 128
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(WORDS)-1:0]   wr_addr,
   input  wire logic [DATA_W-1:0]          wr_data,
   input  wire logic                       rd_en,
   input  wire logic [$clog2(WORDS)-1:0]   rd_addr,
   output logic      [DATA_W-1:0]          rd_data
);

   logic [DATA_W-1:0] mem [WORDS];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hw/rtl/packet_slot_buffer.sv @@
// Top level of the packet slot buffer: slot allocation, ready queue and replay.
// A result passes from acceptance through the read stage, then the output register.
// Throughput: one ingress word per cycle while idle and unstalled; a pull of an L-word
// packet streams one word per cycle, unless the output stalls, out of the single store read port.
// Reset (synchronous, active high) frees every slot, empties the ready queue,
// clears the fill state and the port rewrite enable. The store is not cleared.
`default_nettype none
`include "packet_slot_buffer_macros.svh"

module packet_slot_buffer import psb_pkg::*; #(
   parameter int SLOTS      = 4,
   parameter int SLOT_WORDS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire psb_req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output psb_rsp_type      rsp_data,
   input  wire logic        csr_wr_en,
   input  wire logic        csr_wr_data
);

   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int QC_W   = $clog2(SLOTS + 1);
   localparam int CNT_W  = $clog2(SLOT_WORDS + 1);
   localparam int IDX_W  = $clog2(SLOT_WORDS);
   localparam int WORDS  = SLOTS * SLOT_WORDS;
   localparam int ADDR_W = $clog2(WORDS);

   // Word address of an index within a slot.
   function automatic logic [ADDR_W-1:0] word_addr(input logic [SLOT_W-1:0] slot,
                                                   input logic [IDX_W-1:0] idx);
      return ADDR_W'(int'(slot) * SLOT_WORDS + int'(idx));
   endfunction

   // Control state.
   psb_state_type       state_ff, state_in;
   logic [SLOTS-1:0]    free_map_ff, free_map_in;
   logic                filling_ff, filling_in;
   logic [SLOT_W-1:0]   fill_slot_ff, fill_slot_in;
   logic [CNT_W-1:0]    fill_count_ff, fill_count_in;
   logic [SLOT_W-1:0]   rq_head_ff, rq_head_in;
   logic [QC_W-1:0]     rq_count_ff, rq_count_in;
   logic                rewrite_en_ff;

   // Ready queue storage: slot, length and ending control of each packet.
   logic [SLOT_W-1:0]   rq_slot_ff [SLOTS];
   logic [CNT_W-1:0]    rq_len_ff  [SLOTS];
   logic [CTRL_W-1:0]   rq_ctrl_ff [SLOTS];

   // Packet being replayed.
   logic [SLOT_W-1:0]   stream_slot_ff, stream_slot_in;
   logic [CNT_W-1:0]    stream_len_ff, stream_len_in;
   logic [CTRL_W-1:0]   stream_ctrl_ff, stream_ctrl_in;
   logic [CNT_W-1:0]    stream_idx_ff, stream_idx_in;

   // Read stage: metadata aligned with the store's registered read data.
   logic                rd_valid_ff, rd_valid_in;
   psb_kind_type        rd_kind_ff, rd_kind_in;
   logic [CTRL_W-1:0]   rd_ctrl_ff, rd_ctrl_in;
   logic                rd_last_ff, rd_last_in;
   logic [1:0]          rd_status_ff, rd_status_in;

   // Output register.
   logic                rsp_valid_ff, rsp_valid_in;
   psb_rsp_type         rsp_data_ff, rsp_data_in;

   // Store ports and queue push.
   logic                mem_wr_en;
   logic [ADDR_W-1:0]   mem_wr_addr;
   logic                mem_rd_en;
   logic [ADDR_W-1:0]   mem_rd_addr;
   logic [DATA_W-1:0]   mem_rd_data;
   logic                rq_push;
   logic [SLOT_W-1:0]   rq_tail;
   logic [SLOT_W:0]     rq_tail_sum;
   logic [SLOT_W-1:0]   push_slot;
   logic [CNT_W-1:0]    push_len;

   // Handshake helpers.
   logic                load_out;
   logic                advance;
   logic                req_fire;

   // Lowest free slot.
   logic                free_found;
   logic [SLOT_W-1:0]   free_idx;

   // Working values of the ingress path.
   logic [SLOT_W-1:0]   cur_slot;
   logic [CNT_W-1:0]    cur_count;
   logic [CNT_W-1:0]    new_count;

   // The output register takes the read stage whenever it is empty or being
   // drained. The read stage may take a new word whenever it empties.
   assign load_out  = rd_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign advance   = !rd_valid_ff || load_out;
   assign req_ready = (state_ff == PSB_IDLE) && advance;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int s = SLOTS - 1; s >= 0; s--) begin
         if (free_map_ff[s]) begin
            free_found = 1'b1;
            free_idx   = SLOT_W'(s);
         end
      end
   end

   // The queue index wraps at SLOTS; head plus count stays below twice that.
   assign rq_tail_sum = (SLOT_W + 1)'(rq_head_ff) + (SLOT_W + 1)'(rq_count_ff);
   assign rq_tail     = (rq_tail_sum >= (SLOT_W + 1)'(SLOTS)) ?
                        SLOT_W'(rq_tail_sum - (SLOT_W + 1)'(SLOTS)) : SLOT_W'(rq_tail_sum);

   // Next state, store accesses and read-stage loading.
   always_comb begin
      state_in       = state_ff;
      free_map_in    = free_map_ff;
      filling_in     = filling_ff;
      fill_slot_in   = fill_slot_ff;
      fill_count_in  = fill_count_ff;
      rq_head_in     = rq_head_ff;
      rq_count_in    = rq_count_ff;
      stream_slot_in = stream_slot_ff;
      stream_len_in  = stream_len_ff;
      stream_ctrl_in = stream_ctrl_ff;
      stream_idx_in  = stream_idx_ff;
      rd_valid_in    = load_out ? 1'b0 : rd_valid_ff;
      rd_kind_in     = rd_kind_ff;
      rd_ctrl_in     = rd_ctrl_ff;
      rd_last_in     = rd_last_ff;
      rd_status_in   = rd_status_ff;
      mem_wr_en      = 1'b0;
      mem_wr_addr    = '0;
      mem_rd_en      = 1'b0;
      mem_rd_addr    = '0;
      rq_push        = 1'b0;
      push_slot      = fill_slot_ff;
      push_len       = '0;
      cur_slot       = filling_ff ? fill_slot_ff : free_idx;
      cur_count      = filling_ff ? fill_count_ff : '0;
      new_count      = cur_count;

      case (state_ff)
         PSB_IDLE: begin
            if (req_fire && (req_data.action == ACTION_INGRESS)) begin
               // Every ingress transaction gives one status result.
               rd_valid_in  = 1'b1;
               rd_kind_in   = KIND_RESULT;
               rd_ctrl_in   = CTRL_DATA;
               rd_last_in   = 1'b1;
               rd_status_in = STATUS_WORD;
               if (!filling_ff && !free_found) begin
                  rd_status_in = STATUS_NO_SLOT;
               end else begin
                  if (!filling_ff) begin
                     free_map_in[free_idx] = 1'b0;
                  end
                  fill_slot_in = cur_slot;
                  filling_in   = 1'b1;
                  if (cur_count < CNT_W'(SLOT_WORDS)) begin
                     new_count = CNT_W'(cur_count + 1'b1);
                  end
                  if (req_data.in_ctrl == CTRL_HEADER) begin
                     // A header always lands in word 0.
                     mem_wr_en     = 1'b1;
                     mem_wr_addr   = word_addr(cur_slot, '0);
                     fill_count_in = new_count;
                  end else begin
                     if (cur_count < CNT_W'(SLOT_WORDS)) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = word_addr(cur_slot, cur_count[IDX_W-1:0]);
                     end else begin
                        rd_status_in = STATUS_TOO_LONG;
                     end
                     fill_count_in = new_count;
                     if (req_data.in_ctrl != CTRL_DATA) begin
                        // An end word closes the packet and queues it, or drops it if the queue is full.
                        if (rq_count_ff < QC_W'(SLOTS)) begin
                           rq_push     = 1'b1;
                           push_slot   = cur_slot;
                           push_len    = new_count;
                           rq_count_in = QC_W'(rq_count_ff + 1'b1);
                        end else begin
                           free_map_in[cur_slot] = 1'b1;
                        end
                        filling_in    = 1'b0;
                        fill_count_in = '0;
                     end
                  end
               end
            end else if (req_fire) begin
               rd_valid_in = 1'b1;
               if (rq_count_ff == '0) begin
                  rd_kind_in   = KIND_RESULT;
                  rd_ctrl_in   = CTRL_DATA;
                  rd_last_in   = 1'b1;
                  rd_status_in = STATUS_NO_READY;
               end else begin
                  // Pop the oldest packet and read its first word.
                  rq_head_in   = (rq_head_ff == SLOT_W'(SLOTS - 1)) ? '0 :
                                 SLOT_W'(rq_head_ff + 1'b1);
                  rq_count_in  = QC_W'(rq_count_ff - 1'b1);
                  mem_rd_en    = 1'b1;
                  mem_rd_addr  = word_addr(rq_slot_ff[rq_head_ff], '0);
                  rd_status_in = STATUS_WORD;
                  if (rq_len_ff[rq_head_ff] == CNT_W'(1)) begin
                     // A one-word packet goes out once, unmodified.
                     rd_kind_in = KIND_RAW;
                     rd_ctrl_in = rq_ctrl_ff[rq_head_ff];
                     rd_last_in = 1'b1;
                     free_map_in[rq_slot_ff[rq_head_ff]] = 1'b1;
                  end else begin
                     rd_kind_in     = KIND_HEADER;
                     rd_ctrl_in     = CTRL_HEADER;
                     rd_last_in     = 1'b0;
                     stream_slot_in = rq_slot_ff[rq_head_ff];
                     stream_len_in  = rq_len_ff[rq_head_ff];
                     stream_ctrl_in = rq_ctrl_ff[rq_head_ff];
                     stream_idx_in  = CNT_W'(1);
                     state_in       = PSB_STREAM;
                  end
               end
            end
         end
         PSB_STREAM: begin
            if (advance) begin
               mem_rd_en    = 1'b1;
               mem_rd_addr  = word_addr(stream_slot_ff, stream_idx_ff[IDX_W-1:0]);
               rd_valid_in  = 1'b1;
               rd_kind_in   = KIND_RAW;
               rd_status_in = STATUS_WORD;
               if (CNT_W'(stream_idx_ff + 1'b1) == stream_len_ff) begin
                  // Last word issued: the slot's contents are already read.
                  rd_ctrl_in                  = stream_ctrl_ff;
                  rd_last_in                  = 1'b1;
                  free_map_in[stream_slot_ff] = 1'b1;
                  state_in                    = PSB_IDLE;
               end else begin
                  rd_ctrl_in    = CTRL_DATA;
                  rd_last_in    = 1'b0;
                  stream_idx_in = CNT_W'(stream_idx_ff + 1'b1);
               end
            end
         end
         default: begin
            state_in = PSB_IDLE;
         end
      endcase
   end

   // Output formatting from the read stage.
   always_comb begin
      rsp_data_in           = rsp_data_ff;
      rsp_valid_in          = rsp_ready ? 1'b0 : rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.emit_ctrl = rd_ctrl_ff;
         rsp_data_in.last_word = rd_last_ff;
         rsp_data_in.status    = rd_status_ff;
         case (rd_kind_ff)
            KIND_RAW:    rsp_data_in.emit_data = mem_rd_data;
            KIND_HEADER: rsp_data_in.emit_data = header_word(mem_rd_data, rewrite_en_ff);
            default:     rsp_data_in.emit_data = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= PSB_IDLE;
         free_map_ff   <= '1;
         filling_ff    <= 1'b0;
         fill_slot_ff  <= '0;
         fill_count_ff <= '0;
         rq_head_ff    <= '0;
         rq_count_ff   <= '0;
         rd_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rewrite_en_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         free_map_ff   <= free_map_in;
         filling_ff    <= filling_in;
         fill_slot_ff  <= fill_slot_in;
         fill_count_ff <= fill_count_in;
         rq_head_ff    <= rq_head_in;
         rq_count_ff   <= rq_count_in;
         rd_valid_ff   <= rd_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            rewrite_en_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      stream_slot_ff <= stream_slot_in;
      stream_len_ff  <= stream_len_in;
      stream_ctrl_ff <= stream_ctrl_in;
      stream_idx_ff  <= stream_idx_in;
      rd_kind_ff     <= rd_kind_in;
      rd_ctrl_ff     <= rd_ctrl_in;
      rd_last_ff     <= rd_last_in;
      rd_status_ff   <= rd_status_in;
      rsp_data_ff    <= rsp_data_in;
      if (rq_push) begin
         rq_slot_ff[rq_tail] <= push_slot;
         rq_len_ff[rq_tail]  <= push_len;
         rq_ctrl_ff[rq_tail] <= req_data.in_ctrl;
      end
   end

   psb_store #(
      .WORDS (WORDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (req_data.in_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The slot being filled is never marked free.
   `PSB_ASSERT_IMPLY(a_fill_slot_owned, clock, reset, filling_ff, !free_map_ff[fill_slot_ff])
   // The slot being replayed is never marked free.
   `PSB_ASSERT_IMPLY(a_stream_slot_owned, clock, reset, state_ff == PSB_STREAM,
                     !free_map_ff[stream_slot_ff])
   // The ready queue never holds more packets than there are slots.
   `PSB_ASSERT_IMPLY(a_queue_bound, clock, reset, 1'b1, rq_count_ff <= QC_W'(SLOTS))
   // A replay always has a word left to read.
   `PSB_ASSERT_IMPLY(a_stream_index, clock, reset, state_ff == PSB_STREAM,
                     stream_idx_ff < stream_len_ff)
   // A stalled read stage keeps its word.
   `PSB_ASSERT_NEXT(a_read_stage_held, clock, reset, rd_valid_ff && !load_out, rd_valid_ff)

endmodule

`default_nettype wire
